@@ rtl/waveform_oscillator_mixer_defines.svh @@
// ----------------------------------------------------------------------------
// Waveform oscillator mixer: assertion macros
// Shared property forms for the checker; clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_OSCILLATOR_MIXER_DEFINES_SVH
`define WAVEFORM_OSCILLATOR_MIXER_DEFINES_SVH

// Same-cycle implication, disabled while rst_n is low
`define WOM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wom check failed: same-cycle implication");

// Next-cycle implication, disabled while rst_n is low
`define WOM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wom check failed: next-cycle implication");

`endif

@@ rtl/wom_pkg.sv @@
// ----------------------------------------------------------------------------
// wom_pkg
// Constants, register codes and the quarter-wave sine table of the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package wom_pkg;

  // Phase and sine table geometry
  localparam int PHASE_BITS     = 16;
  localparam int SINE_ADDR_BITS = 10;
  localparam int QUARTER        = 1 << (SINE_ADDR_BITS - 2);
  localparam int SINE_IDX_W     = SINE_ADDR_BITS - 1;

  // Pipeline depth from accepted item to output strobe
  localparam int N_STAGES = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_KIND    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_KIND = 1'b1;

  // Unit wave full scale, Q1.15
  localparam logic signed [16:0] UNIT_ONE = 17'sd32768;

  // Output saturation limits
  localparam logic signed [39:0] SAMPLE_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAMPLE_MIN = -40'sd2147483648;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_RSAW   = 2'd3
  } wave_kind_t;

  typedef enum logic [1:0] {
    COMB_ADD   = 2'd0,
    COMB_BLEND = 2'd1,
    COMB_SUB   = 2'd2,
    COMB_PASS  = 2'd3
  } combine_kind_t;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [15:0] sine_tbl_t [0:QUARTER];

  // One table entry: Taylor series to x^15 in Q2.30, rounded to Q1.15.
  // Evaluated at elaboration only.
  function automatic logic [15:0] sine_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (64'(k) * HALF_PI_Q30) >> (SINE_ADDR_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return r[15:0];
  endfunction

  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t tbl;
    for (int k = 0; k <= QUARTER; k++) begin
      tbl[k] = sine_entry(k);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

`default_nettype wire

@@ rtl/wom_wave.sv @@
// ----------------------------------------------------------------------------
// wom_wave
// Unit wave shaper: phase to sine, square, saw or reverse saw in Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

module wom_wave
  import wom_pkg::*;
(
  input  wire logic [PHASE_BITS-1:0] phase,
  input  wire wave_kind_t            kind,
  output logic signed [16:0]         unit
);

  logic [SINE_ADDR_BITS-1:0] addr;
  logic [SINE_ADDR_BITS-3:0] k_lo;
  logic [SINE_IDX_W-1:0]     idx;
  logic signed [16:0]        mag_s;
  logic signed [16:0]        sine_s;
  logic [15:0]               saw16;
  logic signed [16:0]        saw_s;

  // Table address from phase, scaled to the table width
  if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_shr
    assign addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  end else begin : g_addr_shl
    assign addr = {phase, {(SINE_ADDR_BITS - PHASE_BITS){1'b0}}};
  end

  // Quarter-wave lookup: odd quadrants mirror, upper half negates
  assign k_lo   = addr[SINE_ADDR_BITS-3:0];
  assign idx    = addr[SINE_ADDR_BITS-2] ? (SINE_IDX_W'(QUARTER) - {1'b0, k_lo})
                                         : {1'b0, k_lo};
  assign mag_s  = $signed({1'b0, SINE_TBL[idx]});
  assign sine_s = addr[SINE_ADDR_BITS-1] ? -mag_s : mag_s;

  // Saw ramp: phase scaled to 16 bits
  if (PHASE_BITS == 16) begin : g_saw_eq
    assign saw16 = phase;
  end else if (PHASE_BITS < 16) begin : g_saw_shl
    assign saw16 = {phase, {(16 - PHASE_BITS){1'b0}}};
  end else begin : g_saw_shr
    assign saw16 = phase[PHASE_BITS-1 -: 16];
  end
  assign saw_s = $signed({1'b0, saw16}) - UNIT_ONE;

  // Wave select
  always_comb begin
    case (kind)
      WAVE_SINE:   unit = sine_s;
      WAVE_SQUARE: unit = phase[PHASE_BITS-1] ? -UNIT_ONE : UNIT_ONE;
      WAVE_SAW:    unit = saw_s;
      WAVE_RSAW:   unit = -saw_s;
      default:     unit = saw_s;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/waveform_oscillator_mixer.sv @@
// ----------------------------------------------------------------------------
// waveform_oscillator_mixer
// Oscillator sample (sine/square/saw/reverse saw) mixed into an input sample.
// ----------------------------------------------------------------------------
// One item enters per clock: busy is always low and start is taken every
// cycle it is high. Each item's result is on out_sample_out with out_valid
// high for exactly one cycle, after passing through eight register stages:
// phase multiply, wave lookup, amplitude multiply, wave rounding,
// influence and sample multiplies, product rounding, blend multiply, and
// final rounding, add and saturate. Items leave in the order they came.
// The receiver cannot stall the output, so it must take every strobe.
// Write wave_kind and combine_kind only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_oscillator_mixer
  import wom_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           in_time_now,
  input  wire logic [23:0]           in_frequency,
  input  wire logic signed [15:0]    in_wave_amplitude,
  input  wire logic [15:0]           in_influence,
  input  wire logic signed [31:0]    in_sample_in,
  // results
  output logic                       out_valid,
  output logic signed [31:0]         out_sample_out,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  wave_kind_t    wave_kind_r;
  combine_kind_t combine_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_kind_r    <= WAVE_SINE;
      combine_kind_r <= COMB_ADD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAVE_KIND:    wave_kind_r    <= wave_kind_t'(cfg_data);
        CFG_COMBINE_KIND: combine_kind_r <= combine_kind_t'(cfg_data);
        default:          ;
      endcase
    end
  end

  // Valid bits travel with the stages
  logic                accept;
  logic [N_STAGES-1:0] valid_r;
  logic [N_STAGES-1:0] valid_nxt;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign valid_nxt = {valid_r[N_STAGES-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Stage 1: phase = top fraction bits of time * frequency
  logic [23:0]            frac;
  logic [PHASE_BITS-1:0]  phase1_r;
  logic                   tnz1_r;
  logic signed [15:0]     amp1_r;
  logic [15:0]            infl1_r;
  logic signed [31:0]     smp1_r;

  assign frac = in_time_now[23:0] * in_frequency;

  always_ff @(posedge clk) begin
    phase1_r <= frac[23 -: PHASE_BITS];
    tnz1_r   <= (in_time_now != 32'd0);
    amp1_r   <= in_wave_amplitude;
    infl1_r  <= in_influence;
    smp1_r   <= in_sample_in;
  end

  // Stage 2: unit wave
  logic signed [16:0] unit2;
  logic signed [16:0] u2_r;
  logic               tnz2_r;
  logic signed [15:0] amp2_r;
  logic [15:0]        infl2_r;
  logic signed [31:0] smp2_r;

  wom_wave u_wave (
    .phase (phase1_r),
    .kind  (wave_kind_r),
    .unit  (unit2)
  );

  always_ff @(posedge clk) begin
    u2_r    <= unit2;
    tnz2_r  <= tnz1_r;
    amp2_r  <= amp1_r;
    infl2_r <= infl1_r;
    smp2_r  <= smp1_r;
  end

  // Stage 3: unit wave times amplitude
  logic signed [32:0] pua_nxt;
  logic signed [32:0] pua3_r;
  logic               tnz3_r;
  logic [15:0]        infl3_r;
  logic signed [31:0] smp3_r;

  assign pua_nxt = 33'(u2_r) * 33'(amp2_r);

  always_ff @(posedge clk) begin
    pua3_r  <= pua_nxt;
    tnz3_r  <= tnz2_r;
    infl3_r <= infl2_r;
    smp3_r  <= smp2_r;
  end

  // Stage 4: wave in Q5.16, round half away from zero; zero at time zero
  logic [32:0]        wsum;
  logic signed [20:0] w4_r;
  logic [15:0]        infl4_r;
  logic signed [31:0] smp4_r;

  assign wsum = pua3_r + 33'd1024 - {32'd0, pua3_r[32]};

  always_ff @(posedge clk) begin
    w4_r    <= tnz3_r ? $signed(wsum[31:11]) : 21'sd0;
    infl4_r <= infl3_r;
    smp4_r  <= smp3_r;
  end

  // Stage 5: wave times influence, sample times wave
  logic signed [37:0] pwi_nxt;
  logic signed [52:0] psw_nxt;
  logic signed [37:0] pwi5_r;
  logic signed [52:0] psw5_r;
  logic [15:0]        infl5_r;
  logic signed [31:0] smp5_r;

  assign pwi_nxt = 38'(w4_r) * 38'($signed({1'b0, infl4_r}));
  assign psw_nxt = 53'(smp4_r) * 53'(w4_r);

  always_ff @(posedge clk) begin
    pwi5_r  <= pwi_nxt;
    psw5_r  <= psw_nxt;
    infl5_r <= infl4_r;
    smp5_r  <= smp4_r;
  end

  // Stage 6: round both products; blend difference
  logic [37:0]        wi_sum;
  logic [52:0]        sw_sum;
  logic signed [36:0] m_s;
  logic signed [36:0] diff_nxt;
  logic signed [22:0] rwi6_r;
  logic signed [36:0] diff6_r;
  logic [15:0]        infl6_r;
  logic signed [31:0] smp6_r;

  assign wi_sum   = pwi5_r + 38'd16384 - {37'd0, pwi5_r[37]};
  assign sw_sum   = psw5_r + 53'd32768 - {52'd0, psw5_r[52]};
  assign m_s      = sw_sum[52:16];
  assign diff_nxt = m_s - 37'(smp5_r);

  always_ff @(posedge clk) begin
    rwi6_r  <= wi_sum[37:15];
    diff6_r <= diff_nxt;
    infl6_r <= infl5_r;
    smp6_r  <= smp5_r;
  end

  // Stage 7: blend difference times influence
  logic signed [53:0] pdi_nxt;
  logic signed [53:0] pdi7_r;
  logic signed [22:0] rwi7_r;
  logic signed [31:0] smp7_r;

  assign pdi_nxt = 54'(diff6_r) * 54'($signed({1'b0, infl6_r}));

  always_ff @(posedge clk) begin
    pdi7_r <= pdi_nxt;
    rwi7_r <= rwi6_r;
    smp7_r <= smp6_r;
  end

  // Stage 8: round the blend product, combine and saturate
  logic [53:0]        di_sum;
  logic signed [38:0] blend_d;
  logic signed [39:0] res;
  logic signed [31:0] sat;
  logic signed [31:0] out_r;

  assign di_sum  = pdi7_r + 54'd16384 - {53'd0, pdi7_r[53]};
  assign blend_d = di_sum[53:15];

  always_comb begin
    case (combine_kind_r)
      COMB_ADD:   res = 40'(smp7_r) + 40'(rwi7_r);
      COMB_BLEND: res = 40'(smp7_r) + 40'(blend_d);
      COMB_SUB:   res = 40'(smp7_r) - 40'(rwi7_r);
      COMB_PASS:  res = 40'(smp7_r);
      default:    res = 40'(smp7_r);
    endcase
    if (res > SAMPLE_MAX) begin
      sat = 32'sh7FFFFFFF;
    end else if (res < SAMPLE_MIN) begin
      sat = 32'sh80000000;
    end else begin
      sat = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= sat;
  end

  assign out_valid      = valid_r[N_STAGES-1];
  assign out_sample_out = out_r;

endmodule

`default_nettype wire

@@ rtl/wom_checker.sv @@
// ----------------------------------------------------------------------------
// wom_checker
// Port-level checks of the mixer: fixed latency and zero-wave pass cases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "waveform_oscillator_mixer_defines.svh"

module wom_checker
  import wom_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [31:0]           in_time_now,
  input wire logic signed [31:0]    in_sample_in,
  input wire logic                  out_valid,
  input wire logic signed [31:0]    out_sample_out,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic          acc;
  logic          run_ok;
  logic [7:0]    rst_hist_r;
  combine_kind_t cmb_r;

  assign acc    = start && !busy;
  assign run_ok = &rst_hist_r;

  // History of reset over the pipeline depth
  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[6:0], rst_n};
  end

  // Shadow of the combine register, as seen on the write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmb_r <= COMB_ADD;
    end else if (cfg_we && (cfg_index == CFG_COMBINE_KIND)) begin
      cmb_r <= combine_kind_t'(cfg_data);
    end
  end

  // Every accepted item comes out with a strobe
  `WOM_ASSERT_NOW(a_item_out, run_ok && $past(acc, 8), out_valid)

  // No strobe without an accepted item behind it
  `WOM_ASSERT_NOW(a_no_phantom, run_ok && out_valid, $past(acc, 8))

  // Pass-through mode returns the sample unchanged
  `WOM_ASSERT_NOW(a_pass_sample, run_ok && out_valid && (cmb_r == COMB_PASS),
                  out_sample_out == $past(in_sample_in, 8))

  // At time zero the wave is zero, so add and subtract leave the sample alone
  `WOM_ASSERT_NOW(a_zero_time,
                  run_ok && out_valid && ($past(in_time_now, 8) == 32'd0) &&
                  ((cmb_r == COMB_ADD) || (cmb_r == COMB_SUB)),
                  out_sample_out == $past(in_sample_in, 8))

endmodule

bind waveform_oscillator_mixer wom_checker u_wom_checker (.*);

`default_nettype wire

@@ bench/wom_sample_checker.sv @@
// ----------------------------------------------------------------------------
// wom_sample_checker
// Watches the item, result and register ports of the oscillator mixer. It
// predicts sample_out for every accepted item from its own sine table and
// fixed-point math, and checks each strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module wom_sample_checker
  import wom_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [31:0]           in_time_now,
  input  wire logic [23:0]           in_frequency,
  input  wire logic signed [15:0]    in_wave_amplitude,
  input  wire logic [15:0]           in_influence,
  input  wire logic signed [31:0]    in_sample_in,
  input  wire logic                  out_valid,
  input  wire logic signed [31:0]    out_sample_out,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatch_count,
  output int                         samples_pending
);

  typedef longint unsigned u64_t;

  // Phase width and sine address width of the block
  localparam int   PH_W   = 16;
  localparam int   ADDR_W = 10;
  localparam int   QTR    = 1 << (ADDR_W - 2);
  localparam u64_t PI_HALF_Q2_30 = 64'd1686629713;

  longint        quarter_sine [0:QTR];
  wave_kind_t    cur_wave;
  combine_kind_t cur_combine;
  logic [31:0]   expected_samples [$];
  int            fails;

  // sin(k*pi/(2*QTR)) in Q1.15: odd Taylor terms up to x^15 in Q2.30
  function automatic longint sine_point(input int k);
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint acc;
    x    = (u64_t'(k) * PI_HALF_Q2_30) / u64_t'(QTR);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> 15;
    if (acc > 32768) begin
      acc = 32768;
    end
    return acc;
  endfunction

  initial begin
    for (int k = 0; k <= QTR; k++) begin
      quarter_sine[k] = sine_point(k);
    end
  end

  // Shift right, rounding half away from zero
  function automatic longint round_away(input longint v, input int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] predict_sample_out(
    input wave_kind_t         wk,
    input combine_kind_t      ck,
    input logic [31:0]        t,
    input logic [23:0]        f,
    input logic signed [15:0] amp,
    input logic [15:0]        infl,
    input logic signed [31:0] smp
  );
    u64_t        prod;
    int unsigned phase;
    int unsigned addr;
    int unsigned quad;
    int unsigned k;
    longint      unit_w;
    longint      saw;
    longint      wave;
    longint      s;
    longint      a;
    longint      g;
    longint      m;
    longint      res;
    wave = 0;
    s    = longint'(smp);
    a    = longint'(amp);
    g    = longint'(infl);
    // no oscillator contribution at time zero
    if (t != 32'd0) begin
      prod  = u64_t'(t) * u64_t'(f);
      phase = 32'((prod & 64'hFF_FFFF) >> (24 - PH_W));
      saw   = longint'((u64_t'(phase) << 16) >> PH_W) - 32768;
      case (wk)
        WAVE_SINE: begin
          addr = (phase >> (PH_W - ADDR_W)) & ((1 << ADDR_W) - 1);
          quad = addr >> (ADDR_W - 2);
          k    = addr & (QTR - 1);
          unit_w = quad[0] ? quarter_sine[QTR - k] : quarter_sine[k];
          if (quad[1]) begin
            unit_w = -unit_w;
          end
        end
        WAVE_SQUARE: begin
          unit_w = (phase < (1 << (PH_W - 1))) ? 32768 : -32768;
        end
        WAVE_SAW: begin
          unit_w = saw;
        end
        default: begin
          unit_w = -saw;
        end
      endcase
      wave = round_away(unit_w * a, 11);
    end
    case (ck)
      COMB_ADD: begin
        res = s + round_away(wave * g, 15);
      end
      COMB_BLEND: begin
        m   = round_away(s * wave, 16);
        res = s + round_away((m - s) * g, 15);
      end
      COMB_SUB: begin
        res = s - round_away(wave * g, 15);
      end
      default: begin
        res = s;
      end
    endcase
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
    end
    return res[31:0];
  endfunction

  // Track registers, queue predictions, compare strobed results
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      cur_wave    = WAVE_SINE;
      cur_combine = COMB_ADD;
      expected_samples.delete();
      fails = 0;
      mismatch_count  <= 0;
      samples_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAVE_KIND:    cur_wave    = wave_kind_t'(cfg_data);
          CFG_COMBINE_KIND: cur_combine = combine_kind_t'(cfg_data);
          default:          ;
        endcase
      end
      if (out_valid) begin
        if (expected_samples.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("sample_out 0x%08h strobed with no item outstanding", out_sample_out);
          end
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_sample_out) begin
            fails++;
            if (fails <= 10) begin
              $display("sample_out mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                       $signed(want), want, out_sample_out, out_sample_out);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_samples.push_back(predict_sample_out(cur_wave, cur_combine, in_time_now,
                                                      in_frequency, in_wave_amplitude,
                                                      in_influence, in_sample_in));
      end
      mismatch_count  <= fails;
      samples_pending <= expected_samples.size();
    end
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the oscillator mixer: a directed set covering every wave and
// combine kind, zero time, saturation and influence above one, then random
// items under all sixteen register settings with random gaps and bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import wom_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int ITEMS_PER_SETTING = 110;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  start             = 1'b0;
  logic                  busy;
  logic [31:0]           in_time_now       = '0;
  logic [23:0]           in_frequency      = '0;
  logic signed [15:0]    in_wave_amplitude = '0;
  logic [15:0]           in_influence      = '0;
  logic signed [31:0]    in_sample_in      = '0;
  logic                  out_valid;
  logic signed [31:0]    out_sample_out;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;
  int                    mismatch_count;
  int                    samples_pending;
  int                    cycle_count       = 0;
  int                    burst_left        = 0;
  bit                    no_idle           = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  waveform_oscillator_mixer u_dut (.*);

  wom_sample_checker u_checker (.*);

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[waveform_oscillator_mixer] ERROR");
      $finish;
    end
  end

  // Present one item from the current edge; returns at the edge that takes it
  task automatic present_item(input logic [31:0] t, input logic [23:0] f,
                              input logic [15:0] a, input logic [15:0] g,
                              input logic [31:0] s);
    start             <= 1'b1;
    in_time_now       <= t;
    in_frequency      <= f;
    in_wave_amplitude <= a;
    in_influence      <= g;
    in_sample_in      <= s;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Idle gap per item: none in a no-idle phase or a burst, else 0..11
  function automatic int pick_gap();
    if (no_idle) begin
      return 0;
    end
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Wait for every outstanding result, then let the pipeline settle; start is low
  task automatic drain();
    do @(posedge clk); while (samples_pending != 0);
    repeat (N_STAGES + 2) @(posedge clk);
  endtask

  // Both registers in two back-to-back writes
  task automatic set_kinds(input wave_kind_t wk, input combine_kind_t ck);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WAVE_KIND;
    cfg_data  <= CFG_DATA_W'(wk);
    @(posedge clk);
    cfg_index <= CFG_COMBINE_KIND;
    cfg_data  <= CFG_DATA_W'(ck);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random item with weighted corners on every field
  task automatic send_random();
    logic [31:0] t;
    logic [23:0] f;
    logic [15:0] a;
    logic [15:0] g;
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0:       t = 32'd0;
      1:       t = $urandom_range(1, 255);
      default: t = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       f = 24'($urandom_range(0, 255));
      1:       f = 24'hFF_FFFF;
      default: f = 24'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       a = 16'h8000;
      1:       a = 16'h7FFF;
      default: a = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       g = 16'd0;
      1:       g = 16'($urandom_range(32769, 65535));
      2:       g = 16'd32768;
      default: g = 16'($urandom_range(0, 32768));
    endcase
    case ($urandom_range(0, 9))
      0:       s = 32'h7FFF_FFFF;
      1:       s = 32'h8000_0000;
      2:       s = 32'($urandom_range(0, 65535)) - 32'd32768;
      default: s = $urandom;
    endcase
    present_item(t, f, a, g, s);
  endtask

  initial begin
    int            gap;
    int            pause_at;
    wave_kind_t    wk;
    combine_kind_t ck;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed set; first group runs on the reset settings
    for (int grp = 0; grp < 4; grp++) begin
      if (grp != 0) begin
        set_kinds(wave_kind_t'(grp), combine_kind_t'(grp));
      end
      // zero time, full-scale everything else
      present_item(32'd0, 24'hFF_FFFF, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF);
      hold_off($urandom_range(0, 3));
      // all extremes, influence at its raw maximum
      present_item(32'hFFFF_FFFF, 24'hFF_FFFF, 16'h8000, 16'hFFFF, 32'h8000_0000);
      hold_off($urandom_range(0, 3));
      // phase exactly at one half, sample near the positive limit
      present_item(32'd1, 24'h80_0000, 16'h7FFF, 16'hFFFF, 32'h7FFF_0000);
      hold_off($urandom_range(0, 3));
      // phase zero, unit amplitude, no influence
      present_item(32'h0001_0000, 24'h00_0100, 16'h1000, 16'h0000, 32'h1234_5678);
      hold_off($urandom_range(0, 3));
      // phase near the top, negative overflow
      present_item(32'd3, 24'h55_5555, 16'h7FFF, 16'h8000, 32'h8000_0000);
      hold_off(1 + $urandom_range(0, 3));
      drain();
    end

    // Random items under all sixteen settings, one pause for full drain each
    for (int ph = 0; ph < 16; ph++) begin
      wk      = wave_kind_t'(ph % 4);
      ck      = combine_kind_t'((ph / 4 + ph) % 4);
      no_idle = (ph == 6);
      set_kinds(wk, ck);
      pause_at = $urandom_range(10, ITEMS_PER_SETTING - 10);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        send_random();
        gap = pick_gap();
        if ((i == pause_at || i == ITEMS_PER_SETTING - 1) && gap == 0) begin
          gap = 1;
        end
        hold_off(gap);
        if (i == pause_at) begin
          drain();
        end
      end
      drain();
    end

    repeat (2 * N_STAGES) @(posedge clk);
    if (mismatch_count == 0 && samples_pending == 0) begin
      $display("[waveform_oscillator_mixer] OK");
    end else begin
      $display("[waveform_oscillator_mixer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
